>>> rtl/ste_pkg.sv
// Sorted edge table package: entry layout, compare result, function and status codes.
// Used by ste_key_cmp and sorted_edge_table.
`default_nettype none
package ste_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int VERT_W = 15;
  localparam int ATTR_W = 16;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 9;
  localparam int RIDX_W = 8;

  localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_CONFLICT = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STAT_W-1:0] ST_BADINDEX = 3'd5;

  localparam logic [ATTR_W-1:0] ATTR_NONE = 16'hFFFF;

  typedef struct packed {
    logic [VERT_W-1:0] va;
    logic [VERT_W-1:0] vb;
    logic [ATTR_W-1:0] l0id;
    logic [ATTR_W-1:0] l0pos;
    logic [ATTR_W-1:0] l1id;
    logic [ATTR_W-1:0] l1pos;
    logic [ATTR_W-1:0] ffid;
    logic [ATTR_W-1:0] ffpos;
  } entry_t;

  typedef struct packed {
    logic le;
    logic eq;
  } cmp_res_t;

endpackage
`default_nettype wire

>>> rtl/ste_key_cmp.sv
// Shared key comparator: orders the search key against a stored vertex pair.
// Depends on ste_pkg.
`default_nettype none
module ste_key_cmp (
  input  wire logic [ste_pkg::VERT_W-1:0] key_a,
  input  wire logic [ste_pkg::VERT_W-1:0] key_b,
  input  wire logic [ste_pkg::VERT_W-1:0] ent_a,
  input  wire logic [ste_pkg::VERT_W-1:0] ent_b,
  output ste_pkg::cmp_res_t               res
);
  import ste_pkg::*;

  logic a_eq;

  assign a_eq   = (key_a == ent_a);
  assign res.le = (key_a < ent_a) || (a_eq && (key_b <= ent_b));
  assign res.eq = a_eq && (key_b == ent_b);

endmodule
`default_nettype wire

>>> rtl/sorted_edge_table.sv
// Sorted edge table top level: sequencer, entry memory and result register.
// Depends on ste_pkg and ste_key_cmp.
//
// Usage: one request transaction on in_valid/in_ready (func, vertices, index,
// attributes) gives exactly one result transaction on out_valid/out_ready.
// in_ready is high only while the sequencer is idle; one request is worked on
// at a time. Add and search run a binary search over the stored entries with
// one shared comparator and one memory read port: each probe reads in
// S_SEARCH and compares in S_PROBE. An insert then shifts the later entries
// up one per cycle through the memory port, or goes straight to S_INSERT
// when the new entry goes at the end.
// A read by index reads the entry in S_IDLE and captures it in S_READ.
// Reset empties the table (entry count zero) and drops any pending result;
// memory contents are not cleared, no entry at or beyond the count is used.
// If the receiver stalls, the finished result waits in the output register
// and the sequencer holds until it is taken.
`default_nettype none
module sorted_edge_table #(
  parameter int CAPACITY = ste_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [ste_pkg::FUNC_W-1:0]  func,
  input  wire logic [ste_pkg::VERT_W-1:0]  vert_a,
  input  wire logic [ste_pkg::VERT_W-1:0]  vert_b,
  input  wire logic [ste_pkg::RIDX_W-1:0]  entry_index,
  input  wire logic signed [ste_pkg::ATTR_W-1:0] list_id,
  input  wire logic signed [ste_pkg::ATTR_W-1:0] list_pos,
  input  wire logic signed [ste_pkg::ATTR_W-1:0] facet_id,
  input  wire logic signed [ste_pkg::ATTR_W-1:0] facet_pos,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [ste_pkg::STAT_W-1:0]  status,
  output      logic signed [ste_pkg::FIDX_W-1:0] found_index,
  output      logic signed [ste_pkg::ATTR_W-1:0] out_vert_a,
  output      logic signed [ste_pkg::ATTR_W-1:0] out_vert_b,
  output      logic signed [ste_pkg::ATTR_W-1:0] first_list_id,
  output      logic signed [ste_pkg::ATTR_W-1:0] first_list_pos,
  output      logic signed [ste_pkg::ATTR_W-1:0] second_list_id,
  output      logic signed [ste_pkg::ATTR_W-1:0] second_list_pos,
  output      logic signed [ste_pkg::ATTR_W-1:0] out_facet_id,
  output      logic signed [ste_pkg::ATTR_W-1:0] out_facet_pos
);
  import ste_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_PROBE  = 4'd2;
  localparam logic [3:0] S_MATCH  = 4'd3;
  localparam logic [3:0] S_SHIFT  = 4'd4;
  localparam logic [3:0] S_INSERT = 4'd5;
  localparam logic [3:0] S_READ   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;

  logic [3:0]        state;
  logic [CNT_W-1:0]  count;
  logic [FUNC_W-1:0] func_q;
  logic [VERT_W-1:0] a_q, b_q;
  logic [ATTR_W-1:0] lid_q, lpos_q, fid_q, fpos_q;
  logic [CNT_W-1:0]  lo, hi, mid_q;
  logic              in_range;
  logic [IDX_W-1:0]  r, wa;
  logic              rd_more, pend;
  logic [STAT_W-1:0] res_status;
  logic              res_none;
  entry_t            res_entry;

  entry_t            mem [CAPACITY];
  entry_t            rd_data, wr_data;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic              wr_en;

  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  mid;
  logic [CMP_W-1:0]  ridx_ext, count_ext;
  logic [31:0]       pos_wide;
  cmp_res_t          cmp;
  logic              hit, conflict, out_free;
  entry_t            ins_entry, upd_entry;

  ste_key_cmp u_cmp (
    .key_a (a_q),
    .key_b (b_q),
    .ent_a (rd_data.va),
    .ent_b (rd_data.vb),
    .res   (cmp)
  );

  assign in_ready  = !rst && (state == S_IDLE);
  assign sum       = {1'b0, lo} + {1'b0, hi};
  assign mid       = sum[CNT_W:1];
  assign ridx_ext  = CMP_W'(entry_index);
  assign count_ext = CMP_W'(count);
  assign pos_wide  = 32'(lo);
  assign hit       = in_range && cmp.eq;
  assign conflict  = (rd_data.ffid != fid_q) || (rd_data.ffpos != fpos_q);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    ins_entry       = '{va: a_q, vb: b_q, l0id: lid_q, l0pos: lpos_q,
                        l1id: ATTR_NONE, l1pos: ATTR_NONE, ffid: fid_q, ffpos: fpos_q};
    upd_entry       = rd_data;
    upd_entry.l1id  = lid_q;
    upd_entry.l1pos = lpos_q;
  end

  // memory port control
  always_comb begin
    rd_addr = mid[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = lo[IDX_W-1:0];
    wr_data = ins_entry;
    unique case (state)
      S_IDLE:   rd_addr = ridx_ext[IDX_W-1:0];
      S_SEARCH: rd_addr = (lo < hi) ? mid[IDX_W-1:0] : lo[IDX_W-1:0];
      S_SHIFT: begin
        rd_addr = r;
        wr_en   = pend;
        wr_addr = wa;
        wr_data = rd_data;
      end
      S_MATCH: begin
        wr_en   = hit && (func_q == FN_ADD);
        wr_data = upd_entry;
      end
      S_INSERT: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rd_more <= 1'b0;
      pend    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            a_q    <= (vert_a > vert_b) ? vert_b : vert_a;
            b_q    <= (vert_a > vert_b) ? vert_a : vert_b;
            lid_q  <= list_id;
            lpos_q <= list_pos;
            fid_q  <= facet_id;
            fpos_q <= facet_pos;
            lo     <= (func == FN_READ) ? ridx_ext[CNT_W-1:0] : '0;
            hi     <= count;
            priority if (func == FN_ADD && count >= CAP_CNT) begin
              res_status <= ST_FULL;
              res_none   <= 1'b1;
              state      <= S_EMIT;
            end else if (func == FN_ADD || func == FN_SEARCH) begin
              state <= S_SEARCH;
            end else if (func == FN_READ && ridx_ext < count_ext) begin
              state <= S_READ;
            end else begin
              res_status <= ST_BADINDEX;
              res_none   <= 1'b1;
              state      <= S_EMIT;
            end
          end
        end
        S_SEARCH: begin
          if (lo < hi) begin
            mid_q <= mid;
            state <= S_PROBE;
          end else begin
            in_range <= (lo < count);
            state    <= S_MATCH;
          end
        end
        S_PROBE: begin
          if (cmp.le) begin
            hi <= mid_q;
          end else begin
            lo <= mid_q + 1'b1;
          end
          state <= S_SEARCH;
        end
        S_MATCH: begin
          priority if (hit) begin
            res_none <= 1'b0;
            if (func_q == FN_ADD) begin
              res_entry  <= upd_entry;
              res_status <= conflict ? ST_CONFLICT : ST_UPDATED;
            end else begin
              res_entry  <= rd_data;
              res_status <= ST_OK;
            end
            state <= S_EMIT;
          end else if (func_q == FN_SEARCH) begin
            res_status <= ST_NOTFOUND;
            res_none   <= 1'b1;
            state      <= S_EMIT;
          end else if (lo == count) begin
            state <= S_INSERT;
          end else begin
            r       <= count[IDX_W-1:0] - 1'b1;
            rd_more <= 1'b1;
            pend    <= 1'b0;
            state   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          pend <= rd_more;
          if (rd_more) begin
            wa <= r + 1'b1;
            if (r == lo[IDX_W-1:0]) begin
              rd_more <= 1'b0;
            end else begin
              r <= r - 1'b1;
            end
          end
          if (!rd_more && !pend) begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          count      <= count + 1'b1;
          res_entry  <= ins_entry;
          res_status <= ST_OK;
          res_none   <= 1'b0;
          state      <= S_EMIT;
        end
        S_READ: begin
          res_entry  <= rd_data;
          res_status <= ST_OK;
          res_none   <= 1'b0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      status <= res_status;
      if (res_none) begin
        found_index     <= '1;
        out_vert_a      <= ATTR_NONE;
        out_vert_b      <= ATTR_NONE;
        first_list_id   <= ATTR_NONE;
        first_list_pos  <= ATTR_NONE;
        second_list_id  <= ATTR_NONE;
        second_list_pos <= ATTR_NONE;
        out_facet_id    <= ATTR_NONE;
        out_facet_pos   <= ATTR_NONE;
      end else begin
        found_index     <= pos_wide[FIDX_W-1:0];
        out_vert_a      <= {1'b0, res_entry.va};
        out_vert_b      <= {1'b0, res_entry.vb};
        first_list_id   <= res_entry.l0id;
        first_list_pos  <= res_entry.l0pos;
        second_list_id  <= res_entry.l1id;
        second_list_pos <= res_entry.l1pos;
        out_facet_id    <= res_entry.ffid;
        out_facet_pos   <= res_entry.ffpos;
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_sorted_edge_table.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_edge_table: directed and random add/search/read traffic
// under varying idle and stall patterns, checked against an in-bench model of the table.
// Depends on ste_pkg and the sorted_edge_table RTL.
module tb_sorted_edge_table;
  import ste_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [FIDX_W-1:0] index;
    logic [ATTR_W-1:0] va, vb, l0id, l0pos, l1id, l1pos, ffid, ffpos;
  } edge_reply_t;

  class edge_table_scoreboard;
    entry_t edges[CAP];
    int unsigned n_edges;
    edge_reply_t pending[$];
    int errors;

    function new();
      n_edges = 0;
      errors = 0;
    endfunction

    function edge_reply_t make_reply(logic [STAT_W-1:0] st, int idx);
      edge_reply_t r;
      r.status = st;
      if (idx < 0) begin
        r.index = '1;
        r.va = '1; r.vb = '1; r.l0id = '1; r.l0pos = '1;
        r.l1id = '1; r.l1pos = '1; r.ffid = '1; r.ffpos = '1;
      end else begin
        r.index = idx[FIDX_W-1:0];
        r.va = {1'b0, edges[idx].va};
        r.vb = {1'b0, edges[idx].vb};
        r.l0id = edges[idx].l0id;
        r.l0pos = edges[idx].l0pos;
        r.l1id = edges[idx].l1id;
        r.l1pos = edges[idx].l1pos;
        r.ffid = edges[idx].ffid;
        r.ffpos = edges[idx].ffpos;
      end
      return r;
    endfunction

    // first position whose pair is not below (a, b)
    function int unsigned lower_bound(logic [VERT_W-1:0] a, logic [VERT_W-1:0] b);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = n_edges;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (a < edges[mid].va || (a == edges[mid].va && b <= edges[mid].vb)) hi = mid;
        else lo = mid + 1;
      end
      return lo;
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [VERT_W-1:0] a,
                               logic [VERT_W-1:0] b, logic [RIDX_W-1:0] ridx,
                               logic [ATTR_W-1:0] lid, logic [ATTR_W-1:0] lpos,
                               logic [ATTR_W-1:0] fid, logic [ATTR_W-1:0] fpos);
      logic [VERT_W-1:0] v_lo, v_hi;
      int unsigned pos;
      bit hit, conflict;
      edge_reply_t r;
      v_lo = (a > b) ? b : a;
      v_hi = (a > b) ? a : b;
      pos = lower_bound(v_lo, v_hi);
      hit = pos < n_edges && edges[pos].va == v_lo && edges[pos].vb == v_hi;
      case (f)
        FN_ADD: begin
          if (n_edges >= CAP) begin
            r = make_reply(ST_FULL, -1);
          end else if (hit) begin
            conflict = edges[pos].ffid != fid || edges[pos].ffpos != fpos;
            edges[pos].l1id = lid;
            edges[pos].l1pos = lpos;
            r = make_reply(conflict ? ST_CONFLICT : ST_UPDATED, int'(pos));
          end else begin
            for (int i = n_edges; i > int'(pos); i--) edges[i] = edges[i-1];
            edges[pos].va = v_lo;
            edges[pos].vb = v_hi;
            edges[pos].l0id = lid;
            edges[pos].l0pos = lpos;
            edges[pos].l1id = ATTR_NONE;
            edges[pos].l1pos = ATTR_NONE;
            edges[pos].ffid = fid;
            edges[pos].ffpos = fpos;
            n_edges++;
            r = make_reply(ST_OK, int'(pos));
          end
        end
        FN_SEARCH: r = hit ? make_reply(ST_OK, int'(pos)) : make_reply(ST_NOTFOUND, -1);
        FN_READ: begin
          if (ridx < n_edges) r = make_reply(ST_OK, int'(ridx));
          else r = make_reply(ST_BADINDEX, -1);
        end
        default: r = make_reply(ST_BADINDEX, -1);
      endcase
      pending.push_back(r);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(edge_reply_t got);
      edge_reply_t want;
      if (pending.size() == 0) begin
        $display("%0t: result transaction with none pending, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("status", 16'(want.status), 16'(got.status));
      compare("found_index", 16'(want.index), 16'(got.index));
      compare("out_vert_a", want.va, got.va);
      compare("out_vert_b", want.vb, got.vb);
      compare("first_list_id", want.l0id, got.l0id);
      compare("first_list_pos", want.l0pos, got.l0pos);
      compare("second_list_id", want.l1id, got.l1id);
      compare("second_list_pos", want.l1pos, got.l1pos);
      compare("out_facet_id", want.ffid, got.ffid);
      compare("out_facet_pos", want.ffpos, got.ffpos);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] func = FN_ADD;
  logic [VERT_W-1:0] vert_a = '0;
  logic [VERT_W-1:0] vert_b = '0;
  logic [RIDX_W-1:0] entry_index = '0;
  logic [ATTR_W-1:0] list_id = '0;
  logic [ATTR_W-1:0] list_pos = '0;
  logic [ATTR_W-1:0] facet_id = '0;
  logic [ATTR_W-1:0] facet_pos = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [FIDX_W-1:0] found_index;
  logic [ATTR_W-1:0] out_vert_a, out_vert_b, first_list_id, first_list_pos;
  logic [ATTR_W-1:0] second_list_id, second_list_pos, out_facet_id, out_facet_pos;

  int tx_idle_pct = 23;
  int rx_stall_pct = 45;
  edge_table_scoreboard sb = new();

  sorted_edge_table dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin : result_monitor
    edge_reply_t got;
    if (!rst && out_valid && out_ready) begin
      got.status = status;
      got.index = found_index;
      got.va = out_vert_a;
      got.vb = out_vert_b;
      got.l0id = first_list_id;
      got.l0pos = first_list_pos;
      got.l1id = second_list_id;
      got.l1pos = second_list_pos;
      got.ffid = out_facet_id;
      got.ffpos = out_facet_pos;
      sb.check_result(got);
    end
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_req(logic [FUNC_W-1:0] f, logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                          logic [RIDX_W-1:0] idx, logic [ATTR_W-1:0] lid,
                          logic [ATTR_W-1:0] lpos, logic [ATTR_W-1:0] fid,
                          logic [ATTR_W-1:0] fpos);
    func <= f;
    vert_a <= a;
    vert_b <= b;
    entry_index <= idx;
    list_id <= lid;
    list_pos <= lpos;
    facet_id <= fid;
    facet_pos <= fpos;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(f, a, b, idx, lid, lpos, fid, fpos);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [VERT_W-1:0] rand_vert();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return VERT_W'($urandom_range(0, 12));
      default: return VERT_W'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [ATTR_W-1:0] rand_attr();
    case ($urandom_range(0, 9))
      0: return ATTR_NONE;
      1: return 16'h7FFF;
      2: return '0;
      default: return ATTR_W'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic random_req();
    int sel, k;
    logic [FUNC_W-1:0] f;
    logic [VERT_W-1:0] a, b;
    logic [RIDX_W-1:0] idx;
    logic [ATTR_W-1:0] fid, fpos;
    sel = $urandom_range(0, 99);
    if (sel < 60) f = FN_ADD;
    else if (sel < 78) f = FN_SEARCH;
    else if (sel < 95) f = FN_READ;
    else f = FN_UNUSED;
    a = rand_vert();
    b = rand_vert();
    fid = rand_attr();
    fpos = rand_attr();
    if (sb.n_edges > 0 && $urandom_range(0, 99) < 30) begin
      k = $urandom_range(0, sb.n_edges - 1);
      if ($urandom_range(0, 1)) begin
        a = sb.edges[k].va;
        b = sb.edges[k].vb;
      end else begin
        a = sb.edges[k].vb;
        b = sb.edges[k].va;
      end
      if ($urandom_range(0, 1)) begin
        fid = sb.edges[k].ffid;
        fpos = sb.edges[k].ffpos;
      end
    end
    if (sb.n_edges > 0 && $urandom_range(0, 99) < 70) idx = RIDX_W'($urandom_range(0, sb.n_edges - 1));
    else idx = RIDX_W'($urandom_range(0, 255));
    send_req(f, a, b, idx, rand_attr(), rand_attr(), fid, fpos);
  endtask

  initial begin : stimulus
    int n, n_at_full;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table
    send_req(FN_READ, 15'd0, 15'd0, 8'd0, '0, '0, '0, '0);
    send_req(FN_SEARCH, 15'd5, 15'd7, 8'd0, '0, '0, '0, '0);
    send_req(FN_UNUSED, 15'd1, 15'd2, 8'd0, 16'h7FFF, '0, '0, '0);
    // inserts, swapped pair and vertex extremes
    send_req(FN_ADD, 15'h7FFF, 15'd0, 8'd0, ATTR_NONE, 16'h7FFF, '0, ATTR_NONE);
    send_req(FN_ADD, 15'd0, 15'd0, 8'hFF, '0, ATTR_NONE, 16'h7FFF, '0);
    send_req(FN_ADD, 15'h7FFF, 15'h7FFF, 8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_req(FN_ADD, 15'd7, 15'd3, 8'd0, 16'd1, 16'd2, 16'd10, 16'd20);
    // re-adds: clean update, then facet id and facet pos conflicts
    send_req(FN_ADD, 15'd3, 15'd7, 8'd0, 16'd4, 16'd5, 16'd10, 16'd20);
    send_req(FN_ADD, 15'd7, 15'd3, 8'd0, ATTR_NONE, ATTR_NONE, 16'd11, 16'd20);
    send_req(FN_ADD, 15'd3, 15'd7, 8'd0, 16'd6, 16'd7, 16'd10, 16'd21);
    send_req(FN_SEARCH, 15'd0, 15'h7FFF, 8'd0, '0, '0, '0, '0);
    send_req(FN_SEARCH, 15'h7FFF, 15'd0, 8'd0, '0, '0, '0, '0);
    send_req(FN_SEARCH, 15'd3, 15'd8, 8'd0, '0, '0, '0, '0);
    send_req(FN_SEARCH, 15'h7FFF, 15'h7FFF, 8'd0, '0, '0, '0, '0);
    send_req(FN_READ, 15'd0, 15'd0, 8'd0, '0, '0, '0, '0);
    send_req(FN_READ, 15'd0, 15'd0, 8'd3, '0, '0, '0, '0);
    send_req(FN_READ, 15'd0, 15'd0, 8'd4, '0, '0, '0, '0);
    send_req(FN_READ, 15'd0, 15'd0, 8'hFF, '0, '0, '0, '0);
    send_req(FN_ADD, 15'd0, 15'd1, 8'd0, 16'd9, 16'd9, ATTR_NONE, ATTR_NONE);
    send_req(FN_ADD, 15'd1, 15'd0, 8'd0, 16'd8, 16'd8, ATTR_NONE, ATTR_NONE);
    send_req(FN_UNUSED, 15'd3, 15'd7, 8'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_req(FN_READ, 15'd0, 15'd0, 8'd2, '0, '0, '0, '0);

    for (n = 0; n < 250; n++) random_req();
    tx_idle_pct = 45;
    rx_stall_pct = 23;
    for (n = 0; n < 250; n++) random_req();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    n = 0;
    n_at_full = 0;
    while (n < 250 || n_at_full < 20) begin
      if (sb.n_edges >= CAP) n_at_full++;
      random_req();
      n++;
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
